// File: src/nhbs_pkg.sv
// ----------------------------------------------------------------------------
// nhbs_pkg
// Shared types and constants for the name hash bucket select unit.
// ----------------------------------------------------------------------------
package nhbs_pkg;

  localparam int unsigned LEN_W = 16;

  localparam logic [31:0] HASH_SEED = 32'h5C3F_C4D3;
  localparam logic [31:0] HASH_MUL  = 32'h87C1_0417;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_HMIX,
    ST_HTAIL,
    ST_F1,
    ST_F2,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_K1,
    OP_K2,
    OP_HMIX,
    OP_HTAIL,
    OP_F1,
    OP_F2,
    OP_DIV,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic word_go;
    logic tail_go;
    logic fin_go;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

// File: src/name_hash_bucket_select_unit.sv
// ----------------------------------------------------------------------------
// name_hash_bucket_select_unit
// Streaming 32-bit key hash with reduction to a bucket index.
// ----------------------------------------------------------------------------
// key bytes arrive on the in_ channel, last key byte first, each carrying
// the key length; in_last_byte marks the key's first byte and in_empty_key
// a zero-length key. one transfer on the out_ channel follows each such end.
// cfg_wr_en/cfg_wr_data set the bucket count (reset 1, zero means no
// reduction); write it only while no key is in flight.
// a byte that closes a word steps the shared multiplier through two key
// multiplies and the hash multiply; a tail byte with one byte left also
// runs the hash multiply, and other bytes need no multiply step.
// ending a key adds the avalanche mix (xor-shift, multiply, xor-shift),
// the bit-serial restoring remainder of the 32-bit hash by the bucket
// count and a load of the output register.
// the result sits in an output register, so a stalled receiver only holds
// the unit once a second result is ready to be loaded.
// reset clears the key in progress, drops any held result and sets the
// bucket count back to 1.
// ----------------------------------------------------------------------------
module name_hash_bucket_select_unit import nhbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_key_length,
  input  logic             in_last_byte,
  input  logic             in_empty_key,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_full_hash,
  output logic [31:0]      out_bucket_index,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  nhbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nhbs_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_key_length    (in_key_length),
    .in_last_byte     (in_last_byte),
    .in_empty_key     (in_empty_key),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_full_hash    (out_full_hash),
    .out_bucket_index (out_bucket_index)
  );

endmodule

// File: src/nhbs_ctrl.sv
// ----------------------------------------------------------------------------
// nhbs_ctrl
// Sequencer: steps the shared multiplier, the divider and the result load.
// ----------------------------------------------------------------------------
module nhbs_ctrl import nhbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   fin_pend_r, fin_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fin_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fin_pend_r <= fin_pend_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fin_pend_nxt = fin_pend_r;
    cmd.op       = OP_NONE;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op       = OP_ACCEPT;
          fin_pend_nxt = sts.fin_go;
          if (sts.word_go) begin
            state_nxt = ST_K1;
          end else if (sts.tail_go) begin
            state_nxt = ST_HTAIL;
          end else if (sts.fin_go) begin
            state_nxt = ST_F1;
          end
        end
      end
      ST_K1: begin
        cmd.op    = OP_K1;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        cmd.op    = OP_K2;
        state_nxt = ST_HMIX;
      end
      ST_HMIX: begin
        cmd.op    = OP_HMIX;
        state_nxt = fin_pend_r ? ST_F1 : ST_IDLE;
      end
      ST_HTAIL: begin
        cmd.op    = OP_HTAIL;
        state_nxt = fin_pend_r ? ST_F1 : ST_IDLE;
      end
      ST_F1: begin
        cmd.op    = OP_F1;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        cmd.op    = OP_F2;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!sts.out_busy) begin
          cmd.op       = OP_OUT;
          fin_pend_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/nhbs_dpath.sv
// ----------------------------------------------------------------------------
// nhbs_dpath
// Key state, shared constant multiplier, restoring divider, output register.
// ----------------------------------------------------------------------------
module nhbs_dpath import nhbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_key_length,
  input  logic             in_last_byte,
  input  logic             in_empty_key,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_full_hash,
  output logic [31:0]      out_bucket_index
);

  logic [31:0]      h_r, h_nxt;
  logic [31:0]      wa_r, wa_nxt;
  logic [1:0]       biw_r, biw_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             act_r, act_nxt;
  logic [31:0]      p_r, p_nxt;
  logic [31:0]      dvd_r, dvd_nxt;
  logic [31:0]      drem_r, drem_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [31:0]      bc_r, bc_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      oh_r, oh_nxt;
  logic [31:0]      ob_r, ob_nxt;

  // first-item view of the key state
  logic [31:0]      h0, wa0, h1, wa1, fin_h;
  logic [1:0]       biw0, biw1;
  logic [LEN_W-1:0] rem0, rem1;
  logic             word_go, tail_go, in_word;
  logic [1:0]       tail_sh;

  logic [31:0] mul_a, mul_p;
  logic [32:0] trial, diff;

  always_comb begin
    h0   = act_r ? h_r : (HASH_SEED ^ 32'(in_key_length));
    wa0  = act_r ? wa_r : '0;
    biw0 = act_r ? biw_r : '0;
    rem0 = act_r ? rem_r : in_key_length;
    h1      = h0;
    wa1     = wa0;
    biw1    = biw0;
    rem1    = rem0;
    word_go = 1'b0;
    tail_go = 1'b0;
    in_word = (biw0 != 2'd0) || (rem0 >= LEN_W'(4));
    tail_sh = rem0[1:0] - 2'd1;
    if (rem0 != '0) begin
      if (in_word) begin
        wa1 = wa0 | ({24'd0, in_data_byte} << {biw0, 3'b000});
        if (biw0 == 2'd3) begin
          word_go = 1'b1;
        end
        biw1 = biw0 + 2'd1;
      end else begin
        h1 = h0 ^ ({24'd0, in_data_byte} << {tail_sh, 3'b000});
        tail_go = (rem0 == LEN_W'(1));
      end
      rem1 = rem0 - LEN_W'(1);
    end
  end

  always_comb begin
    case (cmd.op)
      OP_K1:   mul_a = wa_r;
      OP_K2:   mul_a = p_r ^ (p_r >> 24);
      OP_F1:   mul_a = h_r ^ (h_r >> 13);
      default: mul_a = h_r;
    endcase
  end

  assign mul_p = mul_a * HASH_MUL;
  assign fin_h = h_r ^ (h_r >> 15);
  assign trial = {drem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, bc_r};

  always_comb begin
    h_nxt    = h_r;
    wa_nxt   = wa_r;
    biw_nxt  = biw_r;
    rem_nxt  = rem_r;
    act_nxt  = act_r;
    p_nxt    = p_r;
    dvd_nxt  = dvd_r;
    drem_nxt = drem_r;
    cnt_nxt  = cnt_r;
    bc_nxt   = cfg_wr_en ? cfg_wr_data : bc_r;
    ov_nxt   = ov_r & ~out_ready;
    oh_nxt   = oh_r;
    ob_nxt   = ob_r;
    case (cmd.op)
      OP_ACCEPT: begin
        if (in_empty_key) begin
          h_nxt   = HASH_SEED;
          act_nxt = 1'b0;
        end else begin
          h_nxt   = h1;
          wa_nxt  = wa1;
          biw_nxt = biw1;
          rem_nxt = rem1;
          act_nxt = ~in_last_byte;
        end
      end
      OP_K1: p_nxt = mul_p;
      OP_K2: p_nxt = mul_p;
      OP_HMIX: begin
        h_nxt  = mul_p ^ p_r;
        wa_nxt = '0;
      end
      OP_HTAIL: h_nxt = mul_p;
      OP_F1:    h_nxt = mul_p;
      OP_F2: begin
        h_nxt    = fin_h;
        dvd_nxt  = fin_h;
        drem_nxt = '0;
        cnt_nxt  = '0;
      end
      OP_DIV: begin
        drem_nxt = diff[32] ? trial[31:0] : diff[31:0];
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        cnt_nxt  = cnt_r + 5'd1;
      end
      OP_OUT: begin
        ov_nxt = 1'b1;
        oh_nxt = h_r;
        ob_nxt = (bc_r == '0) ? h_r : drem_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      bc_r  <= 32'd1;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      bc_r  <= bc_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    wa_r   <= wa_nxt;
    biw_r  <= biw_nxt;
    rem_r  <= rem_nxt;
    p_r    <= p_nxt;
    dvd_r  <= dvd_nxt;
    drem_r <= drem_nxt;
    cnt_r  <= cnt_nxt;
    oh_r   <= oh_nxt;
    ob_r   <= ob_nxt;
  end

  always_comb begin
    sts.word_go  = word_go & ~in_empty_key;
    sts.tail_go  = tail_go & ~in_empty_key;
    sts.fin_go   = in_last_byte | in_empty_key;
    sts.div_done = (cnt_r == 5'd31);
    sts.out_busy = ov_r & ~out_ready;
  end

  assign out_valid        = ov_r;
  assign out_full_hash    = oh_r;
  assign out_bucket_index = ob_r;

endmodule

// File: test/tb_name_hash_bucket_select_unit.sv
// ----------------------------------------------------------------------------
// tb_name_hash_bucket_select_unit
// Self-checking bench for the streaming key hash and bucket selection.
// ----------------------------------------------------------------------------
// keys are fed last byte first. every accepted transfer is run through a
// bit-accurate predictor of the hash; each key end queues the expected hash
// and bucket, and every out_ transfer is checked against the oldest one.
// a directed part covers the key corner cases, then random keys (mostly
// well-formed, some broken) run under several bucket counts with random
// stalls on one or both channels, and a final stretch runs without any stalls.
// ----------------------------------------------------------------------------
module tb_name_hash_bucket_select_unit import nhbs_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [31:0] full_hash;
    logic [31:0] bucket_index;
  } hash_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = '0;
  logic [LEN_W-1:0] in_key_length = '0;
  logic             in_last_byte = 1'b0;
  logic             in_empty_key = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [31:0]      out_full_hash;
  logic [31:0]      out_bucket_index;
  logic             cfg_wr_en = 1'b0;
  logic [31:0]      cfg_wr_data = '0;

  // predictor state
  logic [31:0]      hash_acc = '0;
  logic [31:0]      word_acc = '0;
  logic [1:0]       word_fill = '0;
  logic [LEN_W-1:0] bytes_left = '0;
  logic             key_open = 1'b0;
  logic [31:0]      bucket_model = 32'd1;

  hash_result_t     predicted_hashes[$];
  int unsigned      items_sent = 0;
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;
  int unsigned      in_gap_pct = 0;
  int unsigned      out_stall_pct = 0;
  int unsigned      stall_left = 0;

  name_hash_bucket_select_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_key_length    (in_key_length),
    .in_last_byte     (in_last_byte),
    .in_empty_key     (in_empty_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_full_hash    (out_full_hash),
    .out_bucket_index (out_bucket_index),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("name_hash_bucket_select_unit verification failed");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic hash_result_t finish_key(input logic [31:0] h);
    hash_result_t res;
    h = h ^ (h >> 13);
    h = h * HASH_MUL;
    h = h ^ (h >> 15);
    res.full_hash = h;
    res.bucket_index = (bucket_model == 0) ? h : h % bucket_model;
    hash_acc = '0;
    word_acc = '0;
    word_fill = '0;
    bytes_left = '0;
    key_open = 1'b0;
    return res;
  endfunction

  // one accepted transfer; returns 1 when it ends a key
  function automatic bit advance_key_hash(input logic [7:0] b, input logic [LEN_W-1:0] len,
                                          input bit is_last, input bit is_empty,
                                          output hash_result_t res);
    logic [31:0] k;
    res = '0;
    if (is_empty) begin
      res = finish_key(HASH_SEED);
      return 1'b1;
    end
    if (!key_open) begin
      key_open = 1'b1;
      bytes_left = len;
      hash_acc = HASH_SEED ^ {{(32 - LEN_W){1'b0}}, len};
      word_acc = '0;
      word_fill = '0;
    end
    if (bytes_left != 0) begin
      if (word_fill != 0 || bytes_left >= 4) begin
        word_acc = word_acc | ({24'b0, b} << (8 * word_fill));
        if (word_fill == 2'd3) begin
          k = word_acc * HASH_MUL;
          k = k ^ (k >> 24);
          k = k * HASH_MUL;
          hash_acc = (hash_acc * HASH_MUL) ^ k;
          word_acc = '0;
          word_fill = '0;
        end else begin
          word_fill = word_fill + 2'd1;
        end
      end else begin
        // tail bytes land at the position of their distance from the key start
        hash_acc = hash_acc ^ ({24'b0, b} << (8 * (bytes_left - 1)));
        if (bytes_left == 1)
          hash_acc = hash_acc * HASH_MUL;
      end
      bytes_left = bytes_left - 1'b1;
    end
    if (is_last) begin
      res = finish_key(hash_acc);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch on %s: expected %08h, got %08h", field, exp_val, act_val);
  endfunction

  always @(posedge clk) begin
    hash_result_t exp_res;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (predicted_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result transfer: hash %08h bucket %08h",
                   out_full_hash, out_bucket_index);
      end else begin
        exp_res = predicted_hashes.pop_front();
        if (out_full_hash !== exp_res.full_hash)
          note_mismatch("full_hash", exp_res.full_hash, out_full_hash);
        if (out_bucket_index !== exp_res.bucket_index)
          note_mismatch("bucket_index", exp_res.bucket_index, out_bucket_index);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic [LEN_W-1:0] len,
                           input bit is_last, input bit is_empty);
    hash_result_t res;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_key_length <= len;
    in_last_byte <= is_last;
    in_empty_key <= is_empty;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (advance_key_hash(b, len, is_last, is_empty, res))
      predicted_hashes = {predicted_hashes, res};
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_key_bytes(input int unsigned nbytes, input logic [LEN_W-1:0] len,
                                input bit vary_len);
    for (int unsigned i = 0; i < nbytes; i++)
      send_item(8'($urandom_range(0, 255)), (i == 0 || !vary_len) ? len : LEN_W'($urandom),
                i == nbytes - 1, 1'b0);
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (predicted_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bucket_model = value;
  endtask

  task automatic send_random_key();
    int unsigned pick;
    int unsigned len;
    int unsigned nbytes;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_key_bytes(len, LEN_W'(len), 1'b0);
    end else if (pick < 85) begin
      send_item(8'($urandom_range(0, 255)), LEN_W'($urandom), 1'($urandom_range(0, 1)),
                1'b1);
    end else if (pick < 88) begin
      // zero length without the empty flag, any bytes ignored
      send_key_bytes($urandom_range(1, 3), '0, 1'b0);
    end else if (pick < 91) begin
      len = $urandom_range(1, 6);
      send_key_bytes(len + $urandom_range(1, 4), LEN_W'(len), 1'b0);
    end else if (pick < 95) begin
      // key cut short, length anywhere in range
      len = $urandom_range(2, 65535);
      nbytes = $urandom_range(1, (len - 1 < 13) ? len - 1 : 13);
      send_key_bytes(nbytes, LEN_W'(len), 1'b0);
    end else if (pick < 98) begin
      len = $urandom_range(2, 20);
      nbytes = $urandom_range(1, len - 1);
      for (int unsigned i = 0; i < nbytes; i++)
        send_item(8'($urandom_range(0, 255)), LEN_W'(len), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), LEN_W'($urandom), 1'($urandom_range(0, 1)),
                1'b1);
    end else begin
      len = $urandom_range(1, 12);
      send_key_bytes(len, LEN_W'(len), 1'b1);
    end
  endtask

  task automatic run_key_phase(input logic [31:0] buckets, input int unsigned n_items,
                               input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned target;
    wait_until_idle();
    write_bucket_count(buckets);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) send_random_key();
  endtask

  // corner cases under the reset bucket count
  task automatic test_directed_keys();
    in_gap_pct = 20;
    out_stall_pct = 20;
    send_item(8'hFF, '1, 1'b1, 1'b1);
    send_item(8'hFF, 16'd1, 1'b1, 1'b0);
    send_item(8'h00, 16'd3, 1'b0, 1'b0);
    send_item(8'hFF, 16'd3, 1'b0, 1'b0);
    send_item(8'hA5, 16'd3, 1'b1, 1'b0);
    send_key_bytes(4, 16'd4, 1'b0);
    for (int i = 0; i < 4; i++)
      send_item(8'hFF, 16'd5, 1'b0, 1'b0);
    send_item(8'h00, 16'd5, 1'b1, 1'b0);
    send_item(8'h5A, 16'd0, 1'b1, 1'b0);
    send_key_bytes(3, 16'd1, 1'b0);
    send_key_bytes(2, '1, 1'b0);
    send_item(8'h12, 16'd6, 1'b0, 1'b0);
    send_item(8'h34, 16'd6, 1'b0, 1'b0);
    send_item(8'h00, 16'd0, 1'b0, 1'b1);
  endtask

  task automatic test_bucket_sweep();
    run_key_phase(32'hFFFF_FFFF, 340, $urandom_range(5, 40), $urandom_range(5, 40));
    run_key_phase(32'd0, 300, 25, 0);
    run_key_phase($urandom_range(2, 16), 340, 0, 30);
    run_key_phase($urandom, 340, $urandom_range(0, 40), $urandom_range(0, 40));
    run_key_phase(32'd1, 150, 15, 15);
  endtask

  task automatic test_steady_stream();
    run_key_phase($urandom_range(3, 1000), 400, 0, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_keys();
    test_bucket_sweep();
    test_steady_stream();
    wait_until_idle();
    if (mismatches == 0)
      $display("name_hash_bucket_select_unit verification clean");
    else
      $display("name_hash_bucket_select_unit verification failed");
    $finish;
  end

endmodule
